FILE: rtl/lgrs_pkg.sv
// Shared types and constants for the Life row stencil unit.
`timescale 1ns / 1ps
`default_nettype none
package lgrs_pkg;

	localparam int ROW_W = 64;
	localparam int CFG_W = 7;
	localparam logic [CFG_W-1:0] BOARD_WIDTH_RESET = CFG_W'(64);

	// neighbor counts for the Life rule
	localparam logic [3:0] SURVIVE_COUNT = 4'd2;
	localparam logic [3:0] BIRTH_COUNT   = 4'd3;

	typedef struct packed {
		logic [ROW_W-1:0] row_cells;
		logic             last_row;
	} in_item_t;

	typedef struct packed {
		logic [ROW_W-1:0] next_cells;
		logic             final_row;
	} out_item_t;

	// results caused by one input row
	typedef struct packed {
		logic             has_upper;
		logic             has_final;
		logic [ROW_W-1:0] upper_cells;
		logic [ROW_W-1:0] final_cells;
	} q_entry_t;

endpackage
`default_nettype wire

FILE: rtl/lgrs_lane.sv
// One column lane: Life rule for a single cell from its eight neighbors.
`timescale 1ns / 1ps
`default_nettype none
module lgrs_lane
	import lgrs_pkg::*;
(
	input  wire logic [7:0] nbrs,
	input  wire logic       alive,
	output logic            next_alive
);

	logic [3:0] cnt;

	always_comb begin
		cnt = 4'd0;
		for (int i = 0; i < 8; i++) begin
			cnt = cnt + 4'(nbrs[i]);
		end
		next_alive = (cnt == BIRTH_COUNT) || (alive && (cnt == SURVIVE_COUNT));
	end

endmodule
`default_nettype wire

FILE: rtl/lgrs_row_eval.sv
// Row evaluator: column lanes side by side, merged into one masked row.
`timescale 1ns / 1ps
`default_nettype none
module lgrs_row_eval
	import lgrs_pkg::*;
#(
	parameter int LANES = 64
) (
	input  wire logic [ROW_W-1:0] above,
	input  wire logic [ROW_W-1:0] mid,
	input  wire logic [ROW_W-1:0] below,
	input  wire logic [ROW_W-1:0] mask,
	output logic      [ROW_W-1:0] next_row
);

	// one dead column of padding on each side
	logic [ROW_W+1:0] a_pad, m_pad, b_pad;
	logic [ROW_W-1:0] lane_out;

	assign a_pad = {1'b0, above & mask, 1'b0};
	assign m_pad = {1'b0, mid & mask, 1'b0};
	assign b_pad = {1'b0, below & mask, 1'b0};

	for (genvar c = 0; c < ROW_W; c++) begin : g_col
		if (c < LANES) begin : g_lane
			lgrs_lane u_lane (
				.nbrs       ({a_pad[c+2:c], m_pad[c+2], m_pad[c], b_pad[c+2:c]}),
				.alive      (m_pad[c+1]),
				.next_alive (lane_out[c])
			);
		end else begin : g_dead
			assign lane_out[c] = 1'b0;
		end
	end

	assign next_row = lane_out & mask;

endmodule
`default_nettype wire

FILE: rtl/lgrs_out_queue.sv
// Two-entry result queue; each entry holds the one or two rows of one input.
`timescale 1ns / 1ps
`default_nettype none
module lgrs_out_queue
	import lgrs_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      push,
	input  wire q_entry_t  push_entry,
	output logic           full,
	output logic           out_valid,
	input  wire logic      out_stall,
	output out_item_t      out_data
);

	q_entry_t   entries_q [2];
	logic       wr_q, rd_q, sel_q;
	logic [1:0] count_q;
	q_entry_t   head;
	logic       xfer, pop, both;

	assign head      = entries_q[rd_q];
	assign full      = (count_q == 2'd2);
	assign out_valid = (count_q != 2'd0);
	assign both      = head.has_upper && head.has_final;
	assign xfer      = out_valid && !out_stall;
	// entry leaves with its last row
	assign pop       = xfer && (!both || sel_q);

	always_comb begin
		if (head.has_upper && !sel_q) begin
			out_data.next_cells = head.upper_cells;
			out_data.final_row  = 1'b0;
		end else begin
			out_data.next_cells = head.final_cells;
			out_data.final_row  = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= 1'b0;
			rd_q    <= 1'b0;
			sel_q   <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q  <= ~rd_q;
				sel_q <= 1'b0;
			end else if (xfer) begin
				sel_q <= 1'b1;
			end
			count_q <= count_q + 2'(push) - 2'(pop);
		end
	end

endmodule
`default_nettype wire

FILE: rtl/life_generation_row_stencil_unit.sv
// Top level: one generation of Life, computed row by row.
// Usage:
//  - Input channel (in_valid / in_stall / in_data) takes one board row per
//    transfer, top row first; last_row marks the bottom row.
//  - Output channel (out_valid / out_stall / out_data) gives next-generation
//    rows in board order; final_row marks the bottom row result.
//  - The first row of a board gives no result (unless it is the bottom row); each later
//    row gives the row above it; the bottom row gives itself too, after the row above.
//  - Config channel (cfg_valid / cfg_ready / cfg_data) sets board_width;
//    always ready. Columns at or above the width are dead.
//  - Results are registered in the output queue when their input transfers, and are offered in order from there.
//  - Throughput: one row per cycle while in_stall is low; the bottom row's two results leave
//    the output port one after the other. 64 column lanes evaluate a whole row at once.
//  - Receiver stall: results wait in a two-entry queue; in_stall rises
//    when the queue is full.
//  - Reset: stored rows cleared, new board, board_width = 64, queue empty.
`timescale 1ns / 1ps
`default_nettype none
module life_generation_row_stencil_unit
	import lgrs_pkg::*;
#(
	parameter int MAX_WIDTH = 64
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_stall,
	input  wire in_item_t         in_data,
	output logic                  out_valid,
	input  wire logic             out_stall,
	output out_item_t             out_data,
	input  wire logic             cfg_valid,
	output logic                  cfg_ready,
	input  wire logic [CFG_W-1:0] cfg_data
);

	logic [CFG_W-1:0] board_width_q;
	logic [ROW_W-1:0] upper_q, middle_q;
	logic [1:0]       rows_q;
	logic [ROW_W-1:0] mask, row, final_above;
	logic [ROW_W-1:0] upper_res, final_res;
	logic             accept, started, push, full;
	q_entry_t         entry;

	assign cfg_ready = 1'b1;

	always_comb begin
		for (int c = 0; c < ROW_W; c++) begin
			mask[c] = (c < MAX_WIDTH) && (board_width_q > CFG_W'(c));
		end
	end

	assign in_stall    = full;
	assign accept      = in_valid && !in_stall;
	assign started     = (rows_q != 2'd0);
	assign row         = in_data.row_cells & mask;
	assign final_above = started ? middle_q : '0;

	lgrs_row_eval #(.LANES(MAX_WIDTH)) u_eval_upper (
		.above    (upper_q),
		.mid      (middle_q),
		.below    (row),
		.mask     (mask),
		.next_row (upper_res)
	);

	lgrs_row_eval #(.LANES(MAX_WIDTH)) u_eval_final (
		.above    (final_above),
		.mid      (row),
		.below    ('0),
		.mask     (mask),
		.next_row (final_res)
	);

	assign entry.has_upper   = started;
	assign entry.has_final   = in_data.last_row;
	assign entry.upper_cells = upper_res;
	assign entry.final_cells = final_res;
	assign push = accept && (started || in_data.last_row);

	lgrs_out_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (entry),
		.full       (full),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_data   (out_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			board_width_q <= BOARD_WIDTH_RESET;
			upper_q       <= '0;
			middle_q      <= '0;
			rows_q        <= 2'd0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				board_width_q <= cfg_data;
			end
			if (accept) begin
				if (in_data.last_row) begin
					// board done, next row opens a new one
					upper_q  <= '0;
					middle_q <= '0;
					rows_q   <= 2'd0;
				end else begin
					upper_q  <= final_above;
					middle_q <= row;
					if (rows_q != 2'd2) begin
						rows_q <= rows_q + 2'd1;
					end
				end
			end
		end
	end

endmodule
`default_nettype wire

FILE: tb/sv/life_generation_row_stencil_unit_tb.sv
// Self-checking testbench for the Life row stencil unit, with its own row-by-row predictor.
`timescale 1ns / 1ps
module life_generation_row_stencil_unit_tb;
	import lgrs_pkg::*;

	localparam int QUIET_LIMIT = 4000;  // cycles with no transfer at all before giving up
	localparam int LONG_HOLD   = 240;
	localparam int MAX_COLS    = 64;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic             in_valid = 1'b0;
	logic             in_stall;
	in_item_t         in_data = '0;
	logic             out_valid;
	logic             out_stall = 1'b0;
	out_item_t        out_data;
	logic             cfg_valid = 1'b0;
	logic             cfg_ready;
	logic [CFG_W-1:0] cfg_data = '0;

	life_generation_row_stencil_unit uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// rows waiting to go in, and next-generation rows waiting to come out
	in_item_t  pending_rows[$];
	out_item_t expected_rows[$];

	// predictor state
	logic [CFG_W-1:0] board_width_now = BOARD_WIDTH_RESET;
	logic [ROW_W-1:0] held_upper = '0;
	logic [ROW_W-1:0] held_middle = '0;
	logic [1:0]       rows_held = '0;

	int rows_pushed = 0;
	int rows_taken = 0;
	int boards_pushed = 0;
	int results_checked = 0;
	int width_writes = 0;
	int errors = 0;
	int quiet = 0;

	int idle_odds = 0;          // 0: no idling, else 1-in-N chance of a burst
	bit long_hold_req = 1'b0;
	bit long_hold_done = 1'b0;
	int long_hold_left = 0;
	int src_gap = 0;
	int sink_gap = 0;
	bit in_fired = 1'b0;

	function automatic logic [ROW_W-1:0] width_mask(input logic [CFG_W-1:0] w);
		if (w >= MAX_COLS)
			return '1;
		return (64'd1 << w) - 64'd1;
	endfunction

	function automatic logic [ROW_W-1:0] life_next(input logic [ROW_W-1:0] above, mid, below,
			mask);
		logic [ROW_W+1:0] pa;
		logic [ROW_W+1:0] pm;
		logic [ROW_W+1:0] pb;
		logic [ROW_W-1:0] nxt;
		int n;
		// one dead column of padding on each side
		pa = {1'b0, above & mask, 1'b0};
		pm = {1'b0, mid & mask, 1'b0};
		pb = {1'b0, below & mask, 1'b0};
		nxt = '0;
		for (int c = 0; c < ROW_W; c++) begin
			n = int'(pa[c]) + int'(pa[c+1]) + int'(pa[c+2]) + int'(pm[c]) + int'(pm[c+2])
				+ int'(pb[c]) + int'(pb[c+1]) + int'(pb[c+2]);
			if (pm[c+1])
				nxt[c] = (n == SURVIVE_COUNT) || (n == BIRTH_COUNT);
			else
				nxt[c] = (n == BIRTH_COUNT);
		end
		return nxt & mask;
	endfunction

	function automatic void predict_row(input in_item_t item);
		logic [ROW_W-1:0] mask;
		logic [ROW_W-1:0] row;
		mask = width_mask(board_width_now);
		row = item.row_cells & mask;
		if (rows_held != 0)
			expected_rows.push_back(out_item_t'{next_cells: life_next(held_upper, held_middle,
				row, mask), final_row: 1'b0});
		if (item.last_row) begin
			expected_rows.push_back(out_item_t'{next_cells: life_next((rows_held != 0) ?
				held_middle : '0, row, '0, mask), final_row: 1'b1});
			held_upper = '0;
			held_middle = '0;
			rows_held = '0;
		end else begin
			held_upper = (rows_held != 0) ? held_middle : '0;
			held_middle = row;
			if (rows_held < 2)
				rows_held = rows_held + 2'd1;
		end
	endfunction

	function automatic void note_fault(input string what, input out_item_t want,
			input out_item_t got);
		errors++;
		if (errors <= 10)
			$display("[%0t] %s: expected cells %h final %b, got cells %h final %b", $realtime,
				what, want.next_cells, want.final_row, got.next_cells, got.final_row);
	endfunction

	// sample at the rising edge: input transfers feed the predictor, output transfers are checked
	always @(posedge clk) begin
		out_item_t want;
		in_fired = arst_n && in_valid && !in_stall;
		if (in_fired) begin
			rows_taken++;
			predict_row(in_data);
		end
		if (arst_n && out_valid && !out_stall) begin
			results_checked++;
			if (expected_rows.size() == 0) begin
				note_fault("unexpected result", '0, out_data);
			end else begin
				want = expected_rows.pop_front();
				if (out_data.next_cells !== want.next_cells || out_data.final_row !== want.final_row)
					note_fault("result mismatch", want, out_data);
			end
		end
	end

	// row driver; valid drops only after a transfer, never because of stall
	always @(negedge clk) begin
		if (arst_n && (!in_valid || in_fired)) begin
			if (in_fired && idle_odds != 0 && $urandom_range(1, idle_odds) == 1)
				src_gap = $urandom_range(1, 11);
			if (src_gap > 0) begin
				src_gap--;
				in_valid <= 1'b0;
			end else if (pending_rows.size() > 0) begin
				in_data <= pending_rows.pop_front();
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// result receiver
	always @(negedge clk) begin
		if (arst_n) begin
			if (long_hold_req && !long_hold_done) begin
				long_hold_done = 1'b1;
				long_hold_left = LONG_HOLD;
			end
			if (long_hold_left > 0) begin
				long_hold_left--;
				out_stall <= 1'b1;
			end else if (sink_gap > 0) begin
				sink_gap--;
				out_stall <= 1'b1;
			end else if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
				sink_gap = $urandom_range(0, 10);
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			quiet = 0;
		else
			quiet++;
		if (quiet >= QUIET_LIMIT) begin
			$display("life_generation_row_stencil_unit_tb failed");
			$finish;
		end
	end

	task automatic push_row(input logic [ROW_W-1:0] cells, input logic last);
		pending_rows.push_back(in_item_t'{row_cells: cells, last_row: last});
		rows_pushed++;
		if (last)
			boards_pushed++;
	endtask

	function automatic logic [ROW_W-1:0] random_row(input int style);
		logic [ROW_W-1:0] r;
		case (style)
			0: r = {$urandom, $urandom};
			1: r = {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
			2: r = {$urandom, $urandom} | {$urandom, $urandom};
			default: begin
				// small shape at a random column, sometimes touching the top column
				r = 64'($urandom_range(0, 255)) << $urandom_range(0, 63);
				if ($urandom_range(0, 3) == 0)
					r[ROW_W-1] = 1'b1;
			end
		endcase
		return r;
	endfunction

	task automatic push_random_boards(input int budget);
		int n;
		int style;
		while (budget > 0) begin
			n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
			style = $urandom_range(0, 3);
			for (int k = 0; k < n; k++)
				push_row(random_row(style), k == n - 1);
			budget -= n;
		end
	endtask

	task automatic write_board_width(input logic [CFG_W-1:0] w);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= w;
		do
			@(posedge clk);
		while (!cfg_ready);
		board_width_now = w;
		width_writes++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// all rows in, all results out, then a pause for a row that gives no result
	task automatic wait_drained();
		do
			@(negedge clk);
		while (rows_taken != rows_pushed || expected_rows.size() != 0);
		repeat (4) @(negedge clk);
	endtask

	initial begin
		logic [CFG_W-1:0] width_plan[8];
		int budget;
		width_plan = '{7'd1, 7'd0, 7'd127, 7'd65, 7'd63, CFG_W'($urandom_range(2, 62)),
			CFG_W'($urandom_range(0, 127)), 7'd64};

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		write_board_width(7'd64);
		idle_odds = 6;
		// single-row boards
		push_row('1, 1'b1);
		push_row('0, 1'b1);
		// blinker
		push_row(64'h0, 1'b0);
		push_row(64'h1C, 1'b0);
		push_row(64'h0, 1'b1);
		// edge columns
		push_row(64'h8000_0000_0000_0001, 1'b0);
		push_row(64'h8000_0000_0000_0001, 1'b0);
		push_row(64'h8000_0000_0000_0001, 1'b1);
		// full board, overcrowded
		push_row('1, 1'b0);
		push_row('1, 1'b0);
		push_row('1, 1'b1);
		// glider
		push_row(64'h2, 1'b0);
		push_row(64'h4, 1'b0);
		push_row(64'h7, 1'b0);
		push_row(64'h0, 1'b0);
		push_row(64'h0, 1'b1);
		// checkerboard
		push_row({32{2'b10}}, 1'b0);
		push_row({32{2'b01}}, 1'b0);
		push_row({32{2'b10}}, 1'b1);
		// two-row board
		push_row(64'hF000_0000_0000_000F, 1'b0);
		push_row(64'hF000_0000_0000_000F, 1'b1);
		wait_drained();

		for (int p = 0; p < 8; p++) begin
			write_board_width(width_plan[p]);
			case (p)
				7: idle_odds = 0;
				1, 4: idle_odds = 3;
				default: idle_odds = 8;
			endcase
			if (p == 2)
				long_hold_req = 1'b1;
			budget = (p < 2) ? 50 : 125;
			push_random_boards(budget);
			// leave a board open so the next width lands mid-board
			if (p != 7) begin
				push_row(random_row(0), 1'b0);
				push_row(random_row(2), 1'b0);
			end
			wait_drained();
		end

		repeat (10) @(negedge clk);
		while (expected_rows.size() != 0)
			note_fault("missing result", expected_rows.pop_front(), '0);

		$display("Covered %0d rows in %0d boards under %0d board width settings;", rows_taken,
			boards_pushed, width_writes);
		$display("%0d results checked, %0d failures.", results_checked, errors);
		if (errors == 0)
			$display("life_generation_row_stencil_unit_tb passed");
		else
			$display("life_generation_row_stencil_unit_tb failed");
		$finish;
	end

endmodule

FILE: sim.f
rtl/lgrs_pkg.sv
rtl/lgrs_lane.sv
rtl/lgrs_row_eval.sv
rtl/lgrs_out_queue.sv
rtl/life_generation_row_stencil_unit.sv
tb/sv/life_generation_row_stencil_unit_tb.sv
